[src/rrts_pkg.sv]
// Package for the round-robin task scheduler: request/result structs, slot
// table entry type, command codes and controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps

package rrts_pkg;

  // Default number of task slots
  localparam int NUM_TASKS_DEF = 8;

  // Reset value of the time-slice length register
  localparam logic [7:0] SLICE_RESET = 8'd16;

  // Command codes carried in the request
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_SLEEP = 3'd1;
  localparam logic [2:0] CMD_BLOCK = 3'd2;
  localparam logic [2:0] CMD_EXIT  = 3'd3;
  localparam logic [2:0] CMD_FORK  = 3'd4;
  localparam logic [2:0] CMD_WAKE  = 3'd5;

  // One request
  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] sleep_ticks;
    logic [2:0]  task_id;
  } in_req_t;

  // One result
  typedef struct packed {
    logic [2:0] running_task;
    logic       switched;
    logic [2:0] forked_task;
    logic       fork_failed;
  } out_rsp_t;

  // Slot lifecycle
  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } slot_state_t;

  // One slot table entry
  typedef struct packed {
    slot_state_t state;
    logic        waits_forever;
    logic [15:0] sleep_left;
  } slot_entry_t;

  // Controller states
  typedef enum logic [2:0] {
    CS_IDLE = 3'd0,
    CS_CUR  = 3'd1,
    CS_WALK = 3'd2,
    CS_SEL  = 3'd3,
    CS_SET  = 3'd4
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the request, read first slot
    logic cur_rd;   // current-task entry available: apply command to it
    logic walk;     // one slot of the table walk
    logic sel;      // slice check and next-task selection
    logic set_run;  // mark the selected task running
    logic finish;   // load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic no_walk;    // command finishes after its first slot access
    logic is_fork;    // fork: walk of all slots, no reschedule
    logic walk_last;  // this walk step visits the last slot
    logic sel_final;  // selection completes without a second access
  } dp_stat_t;

endpackage

[src/rrts_ctrl.sv]
// Controller state machine of the round-robin task scheduler.
// Sequences request acceptance, table walk and reschedule; uses rrts_pkg.
`timescale 1ns / 1ps

module rrts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rrts_pkg::dp_stat_t stat,
  output rrts_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import rrts_pkg::*;

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (start) state_nxt = CS_CUR;
      end
      CS_CUR: begin
        state_nxt = stat.no_walk ? CS_IDLE : CS_WALK;
      end
      CS_WALK: begin
        if (stat.walk_last) state_nxt = stat.is_fork ? CS_IDLE : CS_SEL;
      end
      CS_SEL: begin
        state_nxt = stat.sel_final ? CS_IDLE : CS_SET;
      end
      CS_SET: begin
        state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      CS_IDLE: begin
        busy = 1'b0;
        cmd.accept = start;
      end
      CS_CUR: begin
        cmd.cur_rd = 1'b1;
        cmd.finish = stat.no_walk;
      end
      CS_WALK: begin
        cmd.walk = 1'b1;
        cmd.finish = stat.walk_last && stat.is_fork;
      end
      CS_SEL: begin
        cmd.sel = 1'b1;
        cmd.finish = stat.sel_final;
      end
      CS_SET: begin
        cmd.set_run = 1'b1;
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

[src/rrts_dp.sv]
// Datapath of the round-robin task scheduler: slot table memory with valid
// bits, current task and slice registers, walk counter and result register.
// Uses rrts_pkg; driven by rrts_ctrl.
`timescale 1ns / 1ps

module rrts_dp #(
  parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rrts_pkg::in_req_t  in_req,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  rrts_pkg::dp_cmd_t  cmd,
  output rrts_pkg::dp_stat_t stat,
  output logic               out_valid,
  output rrts_pkg::out_rsp_t out_rsp
);
  import rrts_pkg::*;

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] NUM_S     = SUM_W'(NUM_TASKS);
  localparam logic [IDX_W-1:0] LAST_FORK = IDX_W'(NUM_TASKS - 1);
  localparam logic [IDX_W-1:0] LAST_TICK = IDX_W'(NUM_TASKS - 2);

  // Latched request
  logic [2:0]  cmd_r;
  logic [15:0] ticks_r;
  logic [2:0]  tid_r;

  // Scheduler state
  logic [IDX_W-1:0] cur_r, cur_nxt;
  slot_entry_t      cur_ent_r, cur_ent_nxt;  // current task entry after the command
  logic [7:0]       slice_used_r, slice_used_nxt;
  logic [7:0]       slice_len_r;

  // Walk and search
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] cand_r, cand_nxt;

  // Result
  out_rsp_t out_r, out_nxt;
  logic     out_valid_r;

  // Slot table
  slot_entry_t          mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] valid_r;
  slot_entry_t          rd_q;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 rd_valid_r;
  slot_entry_t          rd_ent;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  slot_entry_t          wr_data;
  logic [IDX_W-1:0]     rd_addr;

  // Helpers
  slot_entry_t      tick_ent;
  logic             extend;
  logic [IDX_W-1:0] new_idx;
  logic             tid_ok;
  logic             is_fork;

  // Slot index base+1+step, modulo the slot count
  function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
                                                input logic [SUM_W-1:0] step);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + step + SUM_W'(1);
    if (s >= NUM_S) s = s - NUM_S;
    return s[IDX_W-1:0];
  endfunction

  // Entry as read; a never-written slot reads as its reset value
  always_comb begin
    if (rd_valid_r) begin
      rd_ent = rd_q;
    end else begin
      rd_ent = '{state: (rd_idx_r == '0) ? ST_RUNNING : ST_DEAD,
                 waits_forever: 1'b0, sleep_left: 16'd0};
    end
  end

  // Timed sleeper countdown for one slot
  always_comb begin
    tick_ent = rd_ent;
    if (rd_ent.state == ST_BLOCKED && !rd_ent.waits_forever) begin
      if (rd_ent.sleep_left <= 16'd1) begin
        tick_ent.state = ST_RUNNABLE;
        tick_ent.sleep_left = 16'd0;
      end else begin
        tick_ent.sleep_left = rd_ent.sleep_left - 16'd1;
      end
    end
  end

  // Slice check and next-task choice
  assign extend  = (cur_ent_r.state == ST_RUNNING) && (slice_used_r < slice_len_r);
  assign new_idx = found_r ? cand_r : ((cur_ent_r.state == ST_RUNNING) ? cur_r : '0);
  assign tid_ok  = 32'(tid_r) < 32'(NUM_TASKS);
  assign is_fork = (cmd_r == CMD_FORK);

  // Status to controller
  always_comb begin
    stat.is_fork   = is_fork;
    stat.no_walk   = !((cmd_r == CMD_TICK) || (cmd_r == CMD_FORK) ||
                       (cmd_r == CMD_BLOCK) || (cmd_r == CMD_EXIT) ||
                       ((cmd_r == CMD_SLEEP) && (ticks_r != 16'd0)));
    stat.walk_last = (cnt_r == (is_fork ? LAST_FORK : LAST_TICK));
    stat.sel_final = extend || (new_idx == cur_r);
  end

  // Per-phase datapath control
  always_comb begin
    cur_nxt        = cur_r;
    cur_ent_nxt    = cur_ent_r;
    slice_used_nxt = slice_used_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    cand_nxt       = cand_r;
    out_nxt        = out_r;
    wr_en          = 1'b0;
    wr_addr        = rd_idx_r;
    wr_data        = rd_ent;
    rd_addr        = cur_r;

    priority if (cmd.accept) begin
      // wake looks at the named slot, everything else at the current task
      found_nxt = 1'b0;
      rd_addr = (in_req.command == CMD_WAKE) ? IDX_W'(in_req.task_id) : cur_r;
    end else if (cmd.cur_rd) begin
      cnt_nxt = '0;
      rd_addr = is_fork ? '0 : ring_idx(cur_r, '0);
      cur_ent_nxt = rd_ent;
      case (cmd_r)
        CMD_SLEEP: begin
          if (ticks_r != 16'd0) begin
            cur_ent_nxt = '{state: ST_BLOCKED, waits_forever: 1'b0, sleep_left: ticks_r};
            wr_en = 1'b1;
            wr_data = cur_ent_nxt;
          end
        end
        CMD_BLOCK: begin
          cur_ent_nxt.state = ST_BLOCKED;
          cur_ent_nxt.waits_forever = 1'b1;
          wr_en = 1'b1;
          wr_data = cur_ent_nxt;
        end
        CMD_EXIT: begin
          cur_ent_nxt.state = ST_DEAD;
          wr_en = 1'b1;
          wr_data = cur_ent_nxt;
        end
        CMD_WAKE: begin
          if (tid_ok && rd_ent.state == ST_BLOCKED) begin
            wr_en = 1'b1;
            wr_data = '{state: ST_RUNNABLE, waits_forever: 1'b0, sleep_left: 16'd0};
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.walk) begin
      // one slot per cycle; the read for the next slot goes out meanwhile
      cnt_nxt = cnt_r + 1'b1;
      if (is_fork) begin
        rd_addr = cnt_r + 1'b1;
        if (rd_ent.state == ST_DEAD && !found_r) begin
          wr_en = 1'b1;
          wr_data = '{state: ST_RUNNABLE, waits_forever: cur_ent_r.waits_forever,
                      sleep_left: cur_ent_r.sleep_left};
          found_nxt = 1'b1;
          cand_nxt = rd_idx_r;
        end
      end else begin
        rd_addr = ring_idx(cur_r, SUM_W'(cnt_r) + SUM_W'(1));
        wr_en = 1'b1;
        wr_data = tick_ent;
        if (tick_ent.state == ST_RUNNABLE && rd_idx_r != '0 && !found_r) begin
          found_nxt = 1'b1;
          cand_nxt = rd_idx_r;
        end
      end
    end else if (cmd.sel) begin
      if (extend) begin
        slice_used_nxt = slice_used_r + 8'd1;
      end else if (new_idx == cur_r) begin
        // current task keeps running (or idle task reruns)
        wr_en = 1'b1;
        wr_addr = cur_r;
        wr_data = cur_ent_r;
        wr_data.state = ST_RUNNING;
        slice_used_nxt = 8'd1;
      end else begin
        // demote the current task, fetch the chosen one
        if (cur_ent_r.state == ST_RUNNING) begin
          wr_en = 1'b1;
          wr_addr = cur_r;
          wr_data = cur_ent_r;
          wr_data.state = ST_RUNNABLE;
        end
        rd_addr = new_idx;
      end
    end else if (cmd.set_run) begin
      wr_en = 1'b1;
      wr_data = rd_ent;
      wr_data.state = ST_RUNNING;
      cur_nxt = rd_idx_r;
      slice_used_nxt = 8'd1;
    end

    // Result
    out_nxt.running_task = 3'(cur_nxt);
    out_nxt.switched     = (cmd.sel && !extend) || cmd.set_run;
    out_nxt.forked_task  = (is_fork && found_nxt) ? 3'(cand_nxt) : 3'd0;
    out_nxt.fork_failed  = is_fork && !found_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      slice_used_r <= 8'd1;
      slice_len_r  <= SLICE_RESET;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_r        <= cur_nxt;
      slice_used_r <= slice_used_nxt;
      cnt_r        <= cnt_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= cmd.finish;
      if (cfg_we) slice_len_r <= cfg_wdata;
      if (wr_en) valid_r[wr_addr] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_req.command;
      ticks_r <= in_req.sleep_ticks;
      tid_r   <= in_req.task_id;
    end
    cur_ent_r <= cur_ent_nxt;
    cand_r    <= cand_nxt;
    if (cmd.finish) out_r <= out_nxt;
  end

  // Slot table: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q       <= mem[rd_addr];
    rd_idx_r   <= rd_addr;
    rd_valid_r <= valid_r[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

`ifndef SYNTH
  a_out_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.running_task == 3'(cur_r)))
    else $error("reported task differs from current task");
  a_slice_nz: assert property (@(posedge clk) disable iff (!rst_n)
    slice_used_r != 8'd0)
    else $error("slice count reached zero");
  a_fork_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.fork_failed) |-> (!out_r.switched && out_r.forked_task == 3'd0))
    else $error("failed fork reported a slot or a switch");
  a_set_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_run |-> $past(cmd.sel))
    else $error("task promotion without selection");
`endif

endmodule

[src/round_robin_task_scheduler.sv]
// Top level of the round-robin task scheduler with sleep timers.
// Instantiates rrts_ctrl and rrts_dp; uses rrts_pkg.
//
//   channel  ports                         handshake
//   request  start, busy, in_req           taken when start && !busy
//   result   out_valid, out_rsp            one-cycle strobe, cannot be held off
//   config   cfg_we, cfg_wdata             slice length, written when cfg_we
//
// After a request is taken busy stays high for the first slot access alone
// (wake, zero sleep, unused codes), for that access and a table walk (fork),
// or for access, walk, selection and, on a switch, a set step (others); the
// result strobe follows in the next cycle, where a new request may already be
// taken. The walk takes one slot per cycle via its one read and one write port.
// Reset (rst_n low, synchronous) leaves task 0 running, all other slots dead.
`timescale 1ns / 1ps

module round_robin_task_scheduler #(
  parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rrts_pkg::in_req_t  in_req,
  output logic               out_valid,
  output rrts_pkg::out_rsp_t out_rsp,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import rrts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Slot table and scheduler registers
  rrts_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

[test/rrts_checker.sv]
// Checker for the round-robin task scheduler: follows the slot table from the
// requests it sees taken, predicts each result and compares it. Uses rrts_pkg.
`timescale 1ns / 1ps

module rrts_checker #(
  parameter int NUM_TASKS = rrts_pkg::NUM_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  rrts_pkg::in_req_t  in_req,
  input  logic               out_valid,
  input  rrts_pkg::out_rsp_t out_rsp,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  output int                 mismatch_count,
  output int                 pending_count
);
  import rrts_pkg::*;

  // Shadow copy of the scheduler state
  slot_state_t slot_q [NUM_TASKS];
  logic [15:0] nap_q  [NUM_TASKS];
  logic        waits_q [NUM_TASKS];
  int          cur_task;
  logic [7:0]  used_q;
  logic [7:0]  slice_q;

  // Results still owed by the block, oldest first
  out_rsp_t    owed_q[$];

  function automatic void clear_schedule();
    for (int i = 0; i < NUM_TASKS; i++) begin
      slot_q[i]  = ST_DEAD;
      nap_q[i]   = 16'd0;
      waits_q[i] = 1'b0;
    end
    slot_q[0] = ST_RUNNING;
    cur_task  = 0;
    used_q    = 8'd1;
    slice_q   = SLICE_RESET;
  endfunction

  // Round-robin pick; task 0 only as the idle fallback
  function automatic void choose_next();
    int  pick;
    int  idx;
    bit  found;
    pick  = cur_task;
    found = 1'b0;
    for (int k = 1; k < NUM_TASKS; k++) begin
      idx = (cur_task + k) % NUM_TASKS;
      if (!found && idx != 0 && slot_q[idx] == ST_RUNNABLE) begin
        pick  = idx;
        found = 1'b1;
      end
    end
    if (slot_q[pick] != ST_RUNNABLE) pick = 0;
    cur_task     = pick;
    slot_q[pick] = ST_RUNNING;
    used_q       = 8'd1;
  endfunction

  // Timer countdown, then slice check; returns 1 when a selection happened
  function automatic logic run_tick();
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (i != cur_task && slot_q[i] == ST_BLOCKED && !waits_q[i]) begin
        if (nap_q[i] <= 16'd1) begin
          nap_q[i]  = 16'd0;
          slot_q[i] = ST_RUNNABLE;
        end else begin
          nap_q[i] = nap_q[i] - 16'd1;
        end
      end
    end
    if (slot_q[cur_task] == ST_RUNNING && used_q < slice_q) begin
      used_q = used_q + 8'd1;
      return 1'b0;
    end
    if (slot_q[cur_task] == ST_RUNNING) begin
      slot_q[cur_task] = ST_RUNNABLE;
      used_q           = 8'd0;
    end
    choose_next();
    return 1'b1;
  endfunction

  function automatic out_rsp_t predict_schedule(input in_req_t req);
    out_rsp_t rsp;
    int       here;
    int       k;
    rsp  = '0;
    here = cur_task;
    case (req.command)
      CMD_TICK: begin
        rsp.switched = run_tick();
      end
      CMD_SLEEP: begin
        // zero-length sleep is a no-op
        if (req.sleep_ticks != 16'd0) begin
          slot_q[here]  = ST_BLOCKED;
          nap_q[here]   = req.sleep_ticks;
          waits_q[here] = 1'b0;
          rsp.switched  = run_tick();
        end
      end
      CMD_BLOCK: begin
        slot_q[here]  = ST_BLOCKED;
        waits_q[here] = 1'b1;
        rsp.switched  = run_tick();
      end
      CMD_EXIT: begin
        slot_q[here] = ST_DEAD;
        rsp.switched = run_tick();
      end
      CMD_FORK: begin
        // child takes the first dead slot and inherits the timer state
        k = 0;
        while (k < NUM_TASKS && slot_q[k] != ST_DEAD) k++;
        if (k < NUM_TASKS) begin
          slot_q[k]       = ST_RUNNABLE;
          nap_q[k]        = nap_q[here];
          waits_q[k]      = waits_q[here];
          rsp.forked_task = 3'(k);
        end else begin
          rsp.fork_failed = 1'b1;
        end
      end
      CMD_WAKE: begin
        if (int'(req.task_id) < NUM_TASKS && slot_q[req.task_id] == ST_BLOCKED) begin
          slot_q[req.task_id]  = ST_RUNNABLE;
          nap_q[req.task_id]   = 16'd0;
          waits_q[req.task_id] = 1'b0;
        end
      end
      default: begin
      end
    endcase
    rsp.running_task = 3'(cur_task);
    return rsp;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    clear_schedule();
  end

  // Results are compared before the request of the same edge is predicted
  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      clear_schedule();
      owed_q.delete();
    end else begin
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, actual %p", $time, out_rsp);
        end else begin
          want = owed_q.pop_front();
          check_field("running_task", 8'(want.running_task), 8'(out_rsp.running_task));
          check_field("switched", 8'(want.switched), 8'(out_rsp.switched));
          check_field("forked_task", 8'(want.forked_task), 8'(out_rsp.forked_task));
          check_field("fork_failed", 8'(want.fork_failed), 8'(out_rsp.fork_failed));
        end
      end
      if (cfg_we) slice_q = cfg_wdata;
      if (start && !busy) owed_q.push_back(predict_schedule(in_req));
    end
    pending_count = owed_q.size();
  end

endmodule

[test/round_robin_task_scheduler_test.sv]
// Top of the scheduler testbench: clock, reset, request and slice-length
// stimulus, and the verdict. Depends on rrts_pkg, the block and rrts_checker.
`timescale 1ns / 1ps

module round_robin_task_scheduler_test;
  import rrts_pkg::*;

  localparam int NUM_TASKS = NUM_TASKS_DEF;
  // Codes the block must treat as no-ops
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int NUM_PHASES       = 5;
  localparam int RANDOM_PER_PHASE = 140;
  localparam int SETTLE_CYCLES    = NUM_TASKS + 6;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_req_t    in_req;
  logic       out_valid;
  out_rsp_t   out_rsp;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         mismatch_count;
  int         pending_count;
  logic [7:0] slice_plan [NUM_PHASES];

  round_robin_task_scheduler #(.NUM_TASKS(NUM_TASKS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  rrts_checker #(.NUM_TASKS(NUM_TASKS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_rsp       (out_rsp),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_req_t make_request(input logic [2:0] cmd,
                                           input logic [15:0] ticks,
                                           input logic [2:0] tid);
    in_req_t req;
    req.command     = cmd;
    req.sleep_ticks = ticks;
    req.task_id     = tid;
    return req;
  endfunction

  // Half ticks and sleeps, most sleeps short, so tasks cycle through every state
  function automatic in_req_t random_request();
    in_req_t req;
    int      roll;
    req.sleep_ticks = 16'($urandom);
    req.task_id     = 3'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 35)      req.command = CMD_TICK;
    else if (roll < 50) req.command = CMD_SLEEP;
    else if (roll < 58) req.command = CMD_BLOCK;
    else if (roll < 66) req.command = CMD_EXIT;
    else if (roll < 80) req.command = CMD_FORK;
    else if (roll < 95) req.command = CMD_WAKE;
    else                req.command = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
    if (req.command == CMD_SLEEP) begin
      roll = $urandom_range(0, 99);
      if (roll < 60)      req.sleep_ticks = 16'($urandom_range(1, 6));
      else if (roll < 75) req.sleep_ticks = 16'($urandom_range(7, 40));
      else if (roll < 85) req.sleep_ticks = 16'd0;
      else if (roll < 95) req.sleep_ticks = 16'($urandom);
      else                req.sleep_ticks = 16'hFFFF;
    end
    return req;
  endfunction

  // Called just after a falling edge; returns after the request is taken
  task automatic send_request(input in_req_t req);
    start  <= 1'b1;
    in_req <= req;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_slice(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drain all owed results, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_count != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_directed();
    // fill the table, then one fork too many
    repeat (8) send_request(make_request(CMD_FORK, 16'h0000, 3'd0));
    send_request(make_request(CMD_TICK, 16'hFFFF, 3'd7));
    send_request(make_request(CMD_SLEEP, 16'h0000, 3'd0));
    send_request(make_request(CMD_SLEEP, 16'hFFFF, 3'd0));
    send_request(make_request(CMD_SLEEP, 16'h0001, 3'd7));
    send_request(make_request(CMD_BLOCK, 16'h0000, 3'd0));
    send_request(make_request(CMD_WAKE, 16'h0000, 3'd7));
    send_request(make_request(CMD_WAKE, 16'hFFFF, 3'd0));
    send_request(make_request(CMD_TICK, 16'h0000, 3'd0));
    send_request(make_request(CMD_SPARE_6, 16'hFFFF, 3'd7));
    send_request(make_request(CMD_SPARE_7, 16'h0000, 3'd0));
    send_request(make_request(CMD_EXIT, 16'h0000, 3'd0));
    send_request(make_request(CMD_TICK, 16'h0000, 3'd0));
    send_request(make_request(CMD_FORK, 16'hFFFF, 3'd7));
    send_request(make_request(CMD_EXIT, 16'h0000, 3'd0));
    send_request(make_request(CMD_EXIT, 16'h0000, 3'd0));
  endtask

  // Main sequence: one slice-length setting per phase
  initial begin
    bit gaps_on;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = 8'd0;
    rst_n     = 1'b0;
    gaps_on   = 1'b0;
    slice_plan[0] = 8'd1;
    slice_plan[1] = 8'd255;
    slice_plan[2] = 8'($urandom_range(2, 8));
    slice_plan[3] = 8'($urandom_range(1, 255));
    slice_plan[4] = SLICE_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_slice(slice_plan[p]);
      if (p == 0) run_directed();
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // gaps come and go in stretches; none in the last phase
        if (n % 35 == 0) gaps_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
        send_request(random_request());
        if (gaps_on && $urandom_range(0, 1) == 1) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 10)) @(negedge clk);
        end
      end
      wait_idle();
    end
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
